// ===== rtl/core/dcc_pkg.sv =====
// Package for the distinct color collector.
// Holds the table depth and the derived widths. No dependencies.
`default_nettype none

package dcc_pkg;

   localparam int TABLE_DEPTH = 1024;

   // Widths of the request and response fields
   localparam int COLOR_W  = 8;
   localparam int ENTRY_W  = 10;
   localparam int UCOUNT_W = 11;

   // Table address and fill count widths follow the depth
   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

   typedef logic [3*COLOR_W-1:0] color_type;
   typedef logic [ADDR_W-1:0]    addr_type;
   typedef logic [CNT_W-1:0]     count_type;

endpackage

`default_nettype wire

// ===== rtl/core/dcc_if.sv =====
// Request and response channel interfaces of the distinct color collector.
// Depend on dcc_pkg for the field widths.
`default_nettype none

interface dcc_req_if;
   import dcc_pkg::*;

   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] pixel_red;
   logic [COLOR_W-1:0] pixel_green;
   logic [COLOR_W-1:0] pixel_blue;
   logic               start_image;

   modport source (output valid, pixel_red, pixel_green, pixel_blue, start_image,
                   input ready);
   modport sink   (input valid, pixel_red, pixel_green, pixel_blue, start_image,
                   output ready);
endinterface

interface dcc_rsp_if;
   import dcc_pkg::*;

   logic                valid;
   logic                ready;
   logic                is_new;
   logic [ENTRY_W-1:0]  entry_index;
   logic [UCOUNT_W-1:0] unique_count;
   logic                overflow;

   modport source (output valid, is_new, entry_index, unique_count, overflow,
                   input ready);
   modport sink   (input valid, is_new, entry_index, unique_count, overflow,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/core/distinct_color_collector.sv =====
// Distinct color collector: top level with the color table and its search sequencer.
// Depends on dcc_pkg and on the channel interfaces in dcc_if.sv.
`default_nettype none

// Each request carries one RGB pixel. The block scans its table of colors seen so
// far, one entry per cycle through the single read port of the table memory, and
// appends a color it does not find. A request with start_image set empties the
// table and clears the sticky overflow flag first. Once a new color finds the
// table full, overflow is set and every further pixel of that image returns
// is_new = 0 and entry_index = 0 without a search. A search for a matching color
// ends at the matching entry, a miss scans every stored color, and an ignored
// pixel or the first color of an image skips the scan. The response sits in an
// output register, so the next request is taken while the previous response still
// waits.
module distinct_color_collector (
   input  wire logic  clock,
   input  wire logic  reset,
   dcc_req_if.sink    req_chan,
   dcc_rsp_if.source  rsp_chan
);
   import dcc_pkg::*;

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_SEARCH  = 2'd1;
   localparam logic [1:0] ST_DELIVER = 2'd2;

   // Color table, single write and single registered read port
   color_type mem [TABLE_DEPTH];
   color_type rd_data_ff;

   logic [1:0] state_ff, state_in;
   count_type  count_ff, count_in;
   logic       ovf_ff, ovf_in;
   color_type  color_ff, color_in;
   addr_type   scan_ff, scan_in;
   logic       done_ff, done_in;
   logic       rd_vld_ff, rd_vld_in;
   addr_type   rd_idx_ff, rd_idx_in;
   logic       pend_new_ff, pend_new_in;
   addr_type   pend_idx_ff, pend_idx_in;

   logic                rsp_vld_ff, rsp_vld_in;
   logic                rsp_new_ff, rsp_new_in;
   logic [ENTRY_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic [UCOUNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic                rsp_ovf_ff, rsp_ovf_in;

   logic      mem_we;
   addr_type  wr_addr;
   color_type wr_data;
   color_type req_color;
   count_type eff_count;
   logic      eff_ovf;
   addr_type  last_idx;
   logic      hit;

   assign req_color = {req_chan.pixel_red, req_chan.pixel_green, req_chan.pixel_blue};
   assign last_idx  = ADDR_W'(count_ff - CNT_W'(1));
   assign hit       = rd_vld_ff && (rd_data_ff == color_ff);

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_vld_ff;
   assign rsp_chan.is_new       = rsp_new_ff;
   assign rsp_chan.entry_index  = rsp_idx_ff;
   assign rsp_chan.unique_count = rsp_cnt_ff;
   assign rsp_chan.overflow     = rsp_ovf_ff;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      color_in    = color_ff;
      scan_in     = scan_ff;
      done_in     = done_ff;
      rd_vld_in   = 1'b0;
      rd_idx_in   = rd_idx_ff;
      pend_new_in = pend_new_ff;
      pend_idx_in = pend_idx_ff;
      rsp_vld_in  = rsp_vld_ff;
      rsp_new_in  = rsp_new_ff;
      rsp_idx_in  = rsp_idx_ff;
      rsp_cnt_in  = rsp_cnt_ff;
      rsp_ovf_in  = rsp_ovf_ff;
      mem_we      = 1'b0;
      wr_addr     = count_ff[ADDR_W-1:0];
      wr_data     = color_ff;
      eff_count   = req_chan.start_image ? '0 : count_ff;
      eff_ovf     = req_chan.start_image ? 1'b0 : ovf_ff;

      // Drop the response once it is taken
      if (rsp_chan.ready) begin
         rsp_vld_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               color_in = req_color;
               count_in = eff_count;
               ovf_in   = eff_ovf;
               if (eff_ovf) begin
                  pend_new_in = 1'b0;
                  pend_idx_in = '0;
                  state_in    = ST_DELIVER;
               end else if (eff_count == '0) begin
                  // Empty table: append without a scan
                  mem_we      = 1'b1;
                  wr_addr     = '0;
                  wr_data     = req_color;
                  count_in    = CNT_W'(1);
                  pend_new_in = 1'b1;
                  pend_idx_in = '0;
                  state_in    = ST_DELIVER;
               end else begin
                  scan_in  = '0;
                  done_in  = 1'b0;
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (hit) begin
               pend_new_in = 1'b0;
               pend_idx_in = rd_idx_ff;
               state_in    = ST_DELIVER;
            end else if (rd_vld_ff && (rd_idx_ff == last_idx)) begin
               // Last stored entry missed: append, or flag a full table
               if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                  ovf_in      = 1'b1;
                  pend_new_in = 1'b0;
                  pend_idx_in = '0;
               end else begin
                  mem_we      = 1'b1;
                  count_in    = count_ff + CNT_W'(1);
                  pend_new_in = 1'b1;
                  pend_idx_in = count_ff[ADDR_W-1:0];
               end
               state_in = ST_DELIVER;
            end else if (!done_ff) begin
               // Issue the next table read
               rd_vld_in = 1'b1;
               rd_idx_in = scan_ff;
               if (scan_ff == last_idx) begin
                  done_in = 1'b1;
               end else begin
                  scan_in = scan_ff + ADDR_W'(1);
               end
            end
         end
         ST_DELIVER: begin
            if (!rsp_vld_ff || rsp_chan.ready) begin
               rsp_vld_in = 1'b1;
               rsp_new_in = pend_new_ff;
               rsp_idx_in = ENTRY_W'(pend_idx_ff);
               rsp_cnt_in = UCOUNT_W'(count_ff);
               rsp_ovf_in = ovf_ff;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[scan_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         ovf_ff     <= 1'b0;
         done_ff    <= 1'b0;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         ovf_ff     <= ovf_in;
         done_ff    <= done_in;
         rd_vld_ff  <= rd_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      color_ff    <= color_in;
      scan_ff     <= scan_in;
      rd_idx_ff   <= rd_idx_in;
      pend_new_ff <= pend_new_in;
      pend_idx_ff <= pend_idx_in;
      rsp_new_ff  <= rsp_new_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("fill count beyond table depth");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> count_ff == CNT_W'(TABLE_DEPTH))
      else $error("overflow set while table not full");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (CNT_W'(rd_idx_ff) < count_ff) && (state_ff == ST_SEARCH))
      else $error("table read outside stored entries");

   a_search_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (count_ff != '0) && !ovf_ff)
      else $error("search started on empty or overflowed table");

   a_new_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DELIVER) && pend_new_ff |->
         (count_ff == CNT_W'(pend_idx_ff) + CNT_W'(1)))
      else $error("appended index does not match fill count");

endmodule

`default_nettype wire
